// ===== rtl/dtmf_pkg.sv =====
// dtmf_pkg: shared constants, coefficient and keypad functions for the dtmf key detector
// no dependencies
`default_nettype none
package dtmf_pkg;
    localparam int ROWS_DEF = 4;
    localparam int COLUMNS_DEF = 3;
    localparam int COEF_FRAC_BITS_DEF = 14;
    localparam int TABLE_FRAC = 20;
    localparam logic [9:0] DC_OFFSET_RST = 10'd468;
    localparam logic [15:0] THRESHOLD_RST = 16'd700;
    localparam logic [7:0] BLOCK_LEN_RST = 8'd100;
    localparam logic [1:0] REG_DC_OFFSET = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_BLOCK_LEN = 2'd2;
    localparam int BIG_Q = 262144;

    function automatic logic [20:0] coef_q20(input logic [2:0] idx);
        logic [20:0] r;
        begin
            case (idx)
                3'd0: r = 21'd1897560;
                3'd1: r = 21'd1837748;
                3'd2: r = 21'd1770684;
                3'd3: r = 21'd1696632;
                3'd4: r = 21'd1435599;
                3'd5: r = 21'd1336775;
                3'd6: r = 21'd1232675;
                default: r = 21'd1010313;
            endcase
            return r;
        end
    endfunction

    function automatic logic [6:0] keypad(input logic [1:0] row, input logic [1:0] col);
        logic [6:0] k;
        begin
            case ({row, col})
                4'h0: k = 7'h31;
                4'h1: k = 7'h32;
                4'h2: k = 7'h33;
                4'h3: k = 7'h41;
                4'h4: k = 7'h34;
                4'h5: k = 7'h35;
                4'h6: k = 7'h36;
                4'h7: k = 7'h42;
                4'h8: k = 7'h37;
                4'h9: k = 7'h38;
                4'ha: k = 7'h39;
                4'hb: k = 7'h43;
                4'hc: k = 7'h2a;
                4'hd: k = 7'h30;
                4'he: k = 7'h23;
                default: k = 7'h44;
            endcase
            return k;
        end
    endfunction
endpackage
`default_nettype wire

// ===== rtl/dtmf_isqrt.sv =====
// dtmf_isqrt: bit-serial integer square root, one result bit per cycle
// depends on nothing
`default_nettype none
module dtmf_isqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] radicand,
    output logic             busy,
    output logic [15:0]      root
);
    logic [33:0] rem_reg;
    logic [31:0] val_reg;
    logic [15:0] root_reg;
    logic [4:0]  cnt_reg;
    logic [33:0] rem_sh;
    logic [33:0] trial;

    assign rem_sh = {rem_reg[31:0], val_reg[31:30]};
    assign trial  = {16'd0, root_reg, 2'b01};
    assign busy   = (cnt_reg != 5'd0);
    assign root   = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 5'd0;
        end
        else if (start)
        begin
            cnt_reg <= 5'd16;
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= 34'd0;
            val_reg  <= radicand;
            root_reg <= 16'd0;
        end
        else if (busy)
        begin
            val_reg <= {val_reg[29:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[14:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/dtmf_goertzel_key_detector_top.sv =====
// dtmf_goertzel_key_detector_top: sample stream in, ascii key stream out
// depends on dtmf_pkg and dtmf_isqrt
`default_nettype none
// Each sample runs through the tones one at a time on one shared 37x22 multiplier, in a
// multiply state and an update state per tone; no new sample is accepted until the last tone
// is updated. A sample that ends a block also does, per tone, four multiplies for the power,
// a bit-serial square root and the max compare, and then a decide state. A key waits in the
// output register while later samples are taken. The next block end holds until that
// register is free.
module dtmf_goertzel_key_detector_top #(
    parameter int ROWS = dtmf_pkg::ROWS_DEF,
    parameter int COLUMNS = dtmf_pkg::COLUMNS_DEF,
    parameter int COEF_FRAC_BITS = dtmf_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // raw_sample[9:0], zero fill
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // key_char[6:0], zero fill
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    localparam int TONES = ROWS + COLUMNS;
    localparam int TW = (TONES > 1) ? $clog2(TONES) : 1;
    localparam int SH = dtmf_pkg::TABLE_FRAC - COEF_FRAC_BITS;
    localparam int CW = 22;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RES_MUL, ST_RES_UPD, ST_P_AA, ST_P_BB, ST_P_AB, ST_P_ABC,
        ST_P_SQ, ST_P_WAIT, ST_NEXT_TONE, ST_DECIDE
    } state_t;

    state_t state_reg;
    logic [9:0]  dc_offset_reg;
    logic [15:0] threshold_reg;
    logic [7:0]  block_len_reg;
    logic [7:0]  count_reg;
    logic [31:0] q1_mem [TONES];
    logic [31:0] q2_mem [TONES];
    logic [TW-1:0] tone_reg;
    logic signed [10:0] samp_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic        big_reg;
    logic [15:0] mag_reg;
    logic        loud_reg;
    logic [15:0] row_best_reg;
    logic [15:0] col_best_reg;
    logic [1:0]  row_idx_reg;
    logic [1:0]  col_idx_reg;
    logic [6:0]  last_key_reg;
    logic        out_valid_reg;
    logic [6:0]  out_key_reg;

    logic signed [CW-1:0] coef;
    logic [20:0] craw;
    logic signed [31:0] q1, q2;
    logic signed [36:0] mul_a;
    logic signed [CW-1:0] mul_b;
    logic signed [63:0] mul_p;
    logic        sq_start, sq_busy;
    logic [15:0] sq_root;
    logic [31:0] rad;
    logic [6:0]  key;
    logic        is_row;
    logic [1:0]  local_idx;

    always_comb
    begin
        if (int'(tone_reg) < ROWS)
        begin
            craw = dtmf_pkg::coef_q20({1'b0, 2'(tone_reg)});
        end
        else
        begin
            craw = dtmf_pkg::coef_q20({1'b1, 2'(int'(tone_reg) - ROWS)});
        end
        if (SH > 0)
        begin
            coef = CW'((craw + 21'((1 << (SH > 0 ? SH - 1 : 0)))) >> SH);
        end
        else
        begin
            coef = CW'(craw);
        end
    end

    assign q1 = q1_mem[tone_reg];
    assign q2 = q2_mem[tone_reg];
    assign is_row = (int'(tone_reg) < ROWS);
    assign local_idx = is_row ? 2'(tone_reg) : 2'(int'(tone_reg) - ROWS);

    always_comb
    begin
        mul_a = 37'(q1);
        mul_b = coef;
        case (state_reg)
            ST_P_AA: mul_b = CW'(q1);
            ST_P_BB:
            begin
                mul_a = 37'(q2);
                mul_b = CW'(q2);
            end
            ST_P_AB: mul_b = CW'(q2);
            ST_P_ABC: mul_a = prod_reg[36:0];
            default: ;
        endcase
    end
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    assign rad = (acc_reg < 0) ? 32'd0 :
                 (acc_reg[63:32] != 32'd0) ? 32'hffffffff : acc_reg[31:0];
    assign sq_start = (state_reg == ST_P_SQ);

    dtmf_isqrt u_isqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(rad),
        .busy(sq_busy), .root(sq_root)
    );

    assign key = dtmf_pkg::keypad(row_idx_reg, col_idx_reg);
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {1'b0, out_key_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_offset_reg <= dtmf_pkg::DC_OFFSET_RST;
            threshold_reg <= dtmf_pkg::THRESHOLD_RST;
            block_len_reg <= dtmf_pkg::BLOCK_LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dtmf_pkg::REG_DC_OFFSET: dc_offset_reg <= cfg_data[9:0];
                dtmf_pkg::REG_THRESHOLD: threshold_reg <= cfg_data;
                dtmf_pkg::REG_BLOCK_LEN: block_len_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= 8'd0;
            tone_reg <= '0;
            last_key_reg <= 7'd0;
            out_valid_reg <= 1'b0;
            out_key_reg <= 7'd0;
            loud_reg <= 1'b0;
            for (int i = 0; i < TONES; i++)
            begin
                q1_mem[i] <= 32'd0;
                q2_mem[i] <= 32'd0;
            end
        end
        else
        begin
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        samp_reg <= $signed({1'b0, s_axis_tdata[9:0]}) -
                                    $signed({1'b0, dc_offset_reg});
                        tone_reg <= '0;
                        state_reg <= ST_RES_MUL;
                    end
                end
                ST_RES_MUL:
                begin
                    prod_reg <= mul_p;
                    state_reg <= ST_RES_UPD;
                end
                ST_RES_UPD:
                begin
                    q1_mem[tone_reg] <= 32'(64'(samp_reg) + (prod_reg >>> COEF_FRAC_BITS)
                                        - 64'(q2));
                    q2_mem[tone_reg] <= q1;
                    if (int'(tone_reg) == TONES - 1)
                    begin
                        tone_reg <= '0;
                        count_reg <= count_reg + 8'd1;
                        if (count_reg + 8'd1 >= block_len_reg)
                        begin
                            loud_reg <= 1'b0;
                            row_best_reg <= 16'd0;
                            col_best_reg <= 16'd0;
                            row_idx_reg <= 2'd0;
                            col_idx_reg <= 2'd0;
                            state_reg <= ST_P_AA;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        tone_reg <= tone_reg + 1'b1;
                        state_reg <= ST_RES_MUL;
                    end
                end
                ST_P_AA:
                begin
                    big_reg <= (q1 >= dtmf_pkg::BIG_Q) || (q1 <= -dtmf_pkg::BIG_Q) ||
                               (q2 >= dtmf_pkg::BIG_Q) || (q2 <= -dtmf_pkg::BIG_Q);
                    acc_reg <= mul_p;
                    state_reg <= ST_P_BB;
                end
                ST_P_BB:
                begin
                    acc_reg <= acc_reg + mul_p;
                    state_reg <= ST_P_AB;
                end
                ST_P_AB:
                begin
                    prod_reg <= mul_p;
                    state_reg <= ST_P_ABC;
                end
                ST_P_ABC:
                begin
                    acc_reg <= acc_reg - (mul_p >>> COEF_FRAC_BITS);
                    state_reg <= ST_P_SQ;
                end
                ST_P_SQ:
                begin
                    state_reg <= ST_P_WAIT;
                end
                ST_P_WAIT:
                begin
                    if (!sq_busy)
                    begin
                        mag_reg <= big_reg ? 16'hffff : sq_root;
                        state_reg <= ST_NEXT_TONE;
                    end
                end
                ST_NEXT_TONE:
                begin
                    if (mag_reg > threshold_reg)
                    begin
                        loud_reg <= 1'b1;
                    end
                    if (is_row && mag_reg > row_best_reg)
                    begin
                        row_best_reg <= mag_reg;
                        row_idx_reg <= local_idx;
                    end
                    if (!is_row && mag_reg > col_best_reg)
                    begin
                        col_best_reg <= mag_reg;
                        col_idx_reg <= local_idx;
                    end
                    if (int'(tone_reg) == TONES - 1)
                    begin
                        state_reg <= ST_DECIDE;
                    end
                    else
                    begin
                        tone_reg <= tone_reg + 1'b1;
                        state_reg <= ST_P_AA;
                    end
                end
                ST_DECIDE:
                begin
                    if (!out_valid_reg)
                    begin
                        if (key != last_key_reg && loud_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            out_key_reg <= key;
                        end
                        last_key_reg <= key;
                        count_reg <= 8'd0;
                        tone_reg <= '0;
                        for (int i = 0; i < TONES; i++)
                        begin
                            q1_mem[i] <= 32'd0;
                            q2_mem[i] <= 32'd0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== tb/dtmf_key_checker.sv =====
// dtmf_key_checker: watches the sample, key and register ports, predicts each key and compares
// depends on dtmf_pkg
`timescale 1ns / 100ps
module dtmf_key_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [7:0]  m_axis_tdata,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output int               errors,
    output int               pending,
    output int               keys_seen
);
    localparam int NROW = dtmf_pkg::ROWS_DEF;
    localparam int NCOL = dtmf_pkg::COLUMNS_DEF;
    localparam int NTONE = NROW + NCOL;
    localparam int FRAC = dtmf_pkg::COEF_FRAC_BITS_DEF;
    localparam longint LIMIT_Q = 262144;

    logic [20:0] coef_tbl [8] = '{21'd1897560, 21'd1837748, 21'd1770684, 21'd1696632,
                                  21'd1435599, 21'd1336775, 21'd1232675, 21'd1010313};
    logic [6:0] key_map [16] = '{7'h31, 7'h32, 7'h33, 7'h41, 7'h34, 7'h35, 7'h36, 7'h42,
                                 7'h37, 7'h38, 7'h39, 7'h43, 7'h2a, 7'h30, 7'h23, 7'h44};

    logic [9:0]  offset_reg;
    logic [15:0] thresh_reg;
    logic [7:0]  blen_reg;
    logic [31:0] res_q1 [NTONE];
    logic [31:0] res_q2 [NTONE];
    logic [7:0]  count_reg;
    logic [15:0] mag_store [NTONE];
    logic [7:0]  prev_key;
    logic [7:0]  key_fifo [$];

    function automatic longint tone_coef(int t);
        longint raw;
        int sh;
        sh = dtmf_pkg::TABLE_FRAC - FRAC;
        raw = (t < NROW) ? coef_tbl[t] : coef_tbl[4 + t - NROW];
        if (sh <= 0)
            return raw;
        return (raw + (longint'(1) << (sh - 1))) >> sh;
    endfunction

    function automatic logic [15:0] root_sat(longint unsigned v);
        longint unsigned res;
        longint unsigned bt;
        res = 0;
        bt = longint'(1) << 62;
        while (bt > v)
            bt = bt >> 2;
        while (bt != 0)
        begin
            if (v >= res + bt)
            begin
                v = v - (res + bt);
                res = (res >> 1) + bt;
            end
            else
                res = res >> 1;
            bt = bt >> 2;
        end
        return (res > 65535) ? 16'hffff : res[15:0];
    endfunction

    function automatic logic [15:0] tone_level(longint a, longint b, longint c);
        longint p;
        if (a >= LIMIT_Q || a <= -LIMIT_Q || b >= LIMIT_Q || b <= -LIMIT_Q)
            return 16'hffff;
        p = a * a + b * b - ((a * b * c) >>> FRAC);
        if (p < 0)
            p = 0;
        return root_sat(p);
    endfunction

    function automatic int loudest(int first, int n);
        logic [15:0] best;
        int idx;
        best = 0;
        idx = 0;
        for (int i = 0; i < n; i++)
        begin
            if (mag_store[first + i] > best)
            begin
                best = mag_store[first + i];
                idx = i;
            end
        end
        return idx;
    endfunction

    function automatic void take_sample(logic [9:0] raw);
        longint s;
        longint a;
        longint b;
        longint q0;
        bit loud;
        int row;
        int col;
        logic [7:0] key;
        s = longint'(raw) - longint'(offset_reg);
        for (int t = 0; t < NTONE; t++)
        begin
            a = longint'(signed'(res_q1[t]));
            b = longint'(signed'(res_q2[t]));
            q0 = s + ((tone_coef(t) * a) >>> FRAC) - b;
            res_q2[t] = res_q1[t];
            res_q1[t] = q0[31:0];
        end
        count_reg = count_reg + 8'd1;
        if (count_reg < blen_reg)
            return;
        loud = 0;
        for (int t = 0; t < NTONE; t++)
        begin
            mag_store[t] = tone_level(longint'(signed'(res_q1[t])),
                                      longint'(signed'(res_q2[t])), tone_coef(t));
            if (mag_store[t] > thresh_reg)
                loud = 1;
        end
        row = loudest(0, NROW) & 3;
        col = loudest(NROW, NCOL) & 3;
        key = {1'b0, key_map[row * 4 + col]};
        if (key != prev_key && loud)
            key_fifo.push_back(key);
        prev_key = key;
        for (int t = 0; t < NTONE; t++)
        begin
            res_q1[t] = 0;
            res_q2[t] = 0;
        end
        count_reg = 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg = dtmf_pkg::DC_OFFSET_RST;
            thresh_reg = dtmf_pkg::THRESHOLD_RST;
            blen_reg = dtmf_pkg::BLOCK_LEN_RST;
            for (int t = 0; t < NTONE; t++)
            begin
                res_q1[t] = 0;
                res_q2[t] = 0;
                mag_store[t] = 0;
            end
            count_reg = 0;
            prev_key = 0;
            key_fifo.delete();
            errors = 0;
            keys_seen = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    dtmf_pkg::REG_DC_OFFSET: offset_reg = cfg_data[9:0];
                    dtmf_pkg::REG_THRESHOLD: thresh_reg = cfg_data;
                    dtmf_pkg::REG_BLOCK_LEN: blen_reg = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                take_sample(s_axis_tdata[9:0]);
            // key transfer
            if (m_axis_tvalid && m_axis_tready)
            begin
                keys_seen++;
                if (key_fifo.size() == 0)
                begin
                    $display("%0t: unexpected key, expected none, got %h", $time, m_axis_tdata);
                    errors++;
                end
                else if (key_fifo[0] !== m_axis_tdata)
                begin
                    $display("%0t: key mismatch, expected %h, got %h", $time, key_fifo[0],
                             m_axis_tdata);
                    errors++;
                    void'(key_fifo.pop_front());
                end
                else
                    void'(key_fifo.pop_front());
            end
            pending = key_fifo.size();
        end
    end
endmodule

// ===== tb/testbench.sv =====
// testbench: drives samples, register writes and output stalls into the dtmf key detector
// depends on dtmf_pkg, dtmf_goertzel_key_detector_top and dtmf_key_checker
`timescale 1ns / 100ps
module testbench;
    localparam int IDLE_WAIT = 400;
    localparam int STALL_LIMIT = 20000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [7:0]  m_axis_tdata;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = 0;
    logic [15:0] cfg_data = 0;
    int          errors;
    int          pending;
    int          keys_seen;
    int          samples_sent = 0;
    int          burst_left = 0;
    int          quiet_cycles = 0;
    int          stall_mode = 0;
    int          stall_timer = 0;
    int          cur_offset = 468;
    real         row_w [4];
    real         col_w [3];

    always #5 clk = ~clk;

    dtmf_goertzel_key_detector_top DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    dtmf_key_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .keys_seen(keys_seen)
    );

    // key receiver stalls, with stretches of always-ready
    always @(posedge clk)
    begin
        if (stall_timer == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_timer <= $urandom_range(50, 400);
        end
        else
            stall_timer <= stall_timer - 1;
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ($urandom_range(0, 40) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("dtmf_goertzel_key_detector_top test failed");
            $finish;
        end
    end

    task automatic send_sample(logic [9:0] v);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, v};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        samples_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 30);
            if ($urandom_range(0, 2) != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    endtask

    task automatic write_regs(logic [9:0] off, logic [15:0] thr, logic [7:0] blen);
        cfg_we <= 1'b1;
        cfg_index <= dtmf_pkg::REG_DC_OFFSET;
        cfg_data <= {6'd0, off};
        @(posedge clk);
        cfg_index <= dtmf_pkg::REG_THRESHOLD;
        cfg_data <= thr;
        @(posedge clk);
        cfg_index <= dtmf_pkg::REG_BLOCK_LEN;
        cfg_data <= {8'd0, blen};
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_offset = int'(off);
    endtask

    task automatic settle;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    // two-tone burst for one block, clipped to the converter range
    task automatic send_tone(int len, int r, int c, int amp_r, int amp_c);
        real v;
        real ph_r;
        real ph_c;
        ph_r = $urandom_range(0, 628) / 100.0;
        ph_c = $urandom_range(0, 628) / 100.0;
        for (int n = 0; n < len; n++)
        begin
            v = cur_offset + amp_r * $sin(row_w[r] * n + ph_r)
                + amp_c * $sin(col_w[c] * n + ph_c);
            if (v < 0.0)
                v = 0.0;
            if (v > 1023.0)
                v = 1023.0;
            send_sample(10'($rtoi(v)));
        end
    endtask

    initial
    begin
        int blen;
        int len;
        row_w[0] = $acos(1.809654104932039 / 2.0);
        row_w[1] = $acos(1.7526133600877272 / 2.0);
        row_w[2] = $acos(1.6886558510040302 / 2.0);
        row_w[3] = $acos(1.618033988749895 / 2.0);
        col_w[0] = $acos(1.3690942118573772 / 2.0);
        col_w[1] = $acos(1.2748479794973793 / 2.0);
        col_w[2] = $acos(1.175570504584946 / 2.0);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // zero block length, extreme samples and offsets, zero threshold
        write_regs(10'd0, 16'd0, 8'd0);
        send_sample(10'd1023);
        send_sample(10'd0);
        send_sample(10'd512);
        settle();
        write_regs(10'd1023, 16'd0, 8'd1);
        send_sample(10'd0);
        send_sample(10'd1023);
        send_sample(10'd1023);
        settle();
        // shortened block length mid-block
        write_regs(10'd512, 16'd65535, 8'd10);
        for (int i = 0; i < 5; i++)
            send_sample(10'($urandom_range(0, 1023)));
        settle();
        write_regs(10'd512, 16'd0, 8'd3);
        send_sample(10'd700);
        send_tone(3, 3, 2, 400, 400);
        settle();
        // full-scale tone over the longest block
        write_regs(10'd512, 16'd100, 8'd255);
        send_tone(255, 0, 0, 511, 0);
        settle();

        while (samples_sent < 1300)
        begin
            case ($urandom_range(0, 9))
                0: blen = 0;
                1: blen = $urandom_range(1, 4);
                2: blen = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(41, 120);
                default: blen = $urandom_range(8, 40);
            endcase
            write_regs(($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
                                                   : 10'($urandom_range(420, 600)),
                       ($urandom_range(0, 9) == 0) ? 16'hffff
                                                   : 16'($urandom_range(0, 3000)),
                       8'(blen));
            len = (blen == 0) ? 1 : blen;
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 4) == 0)
                    for (int i = 0; i < len; i++)
                        send_sample(10'($urandom_range(0, 1023)));
                else
                    send_tone(len, $urandom_range(0, 3), $urandom_range(0, 2),
                              $urandom_range(40, 480), $urandom_range(40, 480));
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(0, len - 1))
                    send_sample(10'($urandom_range(0, 1023)));
            settle();
        end

        if (errors == 0 && pending == 0)
            $display("dtmf_goertzel_key_detector_top test passed");
        else
        begin
            if (pending != 0)
                $display("%0t: %0d expected keys never arrived", $time, pending);
            $display("dtmf_goertzel_key_detector_top test failed");
        end
        $finish;
    end
endmodule

// ===== dtmf_goertzel_key_detector_top.f =====
rtl/dtmf_pkg.sv
rtl/dtmf_isqrt.sv
rtl/dtmf_goertzel_key_detector_top.sv
tb/dtmf_key_checker.sv
tb/testbench.sv
